>>> hdl/vrt_pkg.sv
package vrt_pkg;

    // Sentinel carried on the address and data buses for a power-law vertex.
    localparam int SENTINEL = -2;

    // Per-transaction queue request from the top level.
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    // Queue occupancy, now and after the current requests are applied.
    typedef struct packed {
        logic empty;
        logic full;
        logic empty_next;
        logic full_next;
    } t_q_sts;

    // Per-cell load/shift controls.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

>>> hdl/vrt_upd_if.sv
interface vrt_upd_if #(
    parameter int VERTEX_BITS = 20
);
    logic                          valid;
    logic                          ready;
    logic                          update_valid;
    logic                          update_is_push;
    logic [VERTEX_BITS-1:0]        update_vertex;
    logic [VERTEX_BITS-1:0]        update_value;
    logic                          update_pull_first;
    logic                          iteration_end_in;
    logic                          memory_valid;
    logic signed [VERTEX_BITS:0]   memory_data;
    logic [VERTEX_BITS-1:0]        iteration_number;

    modport source (
        output valid, update_valid, update_is_push, update_vertex, update_value,
               update_pull_first, iteration_end_in, memory_valid, memory_data,
               iteration_number,
        input  ready
    );

    modport sink (
        input  valid, update_valid, update_is_push, update_vertex, update_value,
               update_pull_first, iteration_end_in, memory_valid, memory_data,
               iteration_number,
        output ready
    );
endinterface

>>> hdl/vrt_res_if.sv
interface vrt_res_if #(
    parameter int VERTEX_BITS = 20
);
    logic                          valid;
    logic                          ready;
    logic signed [VERTEX_BITS:0]   read_address;
    logic                          read_valid;
    logic                          out_is_push;
    logic [VERTEX_BITS-1:0]        out_vertex;
    logic [VERTEX_BITS-1:0]        out_value;
    logic                          out_pull_first;
    logic                          out_valid;
    logic                          iteration_end_out;
    logic                          queue_full;

    modport source (
        output valid, read_address, read_valid, out_is_push, out_vertex, out_value,
               out_pull_first, out_valid, iteration_end_out, queue_full,
        input  ready
    );

    modport sink (
        input  valid, read_address, read_valid, out_is_push, out_vertex, out_value,
               out_pull_first, out_valid, iteration_end_out, queue_full,
        output ready
    );
endinterface

>>> hdl/vrt_cell.sv
module vrt_cell #(
    parameter int VERTEX_BITS = 20
) (
    input  logic                   i_clk,
    input  vrt_pkg::t_cell_ctl     i_ctl,
    input  logic [VERTEX_BITS-1:0] i_load_vertex,
    input  logic                   i_load_pf,
    input  logic [VERTEX_BITS-1:0] i_nb_vertex,
    input  logic                   i_nb_pf,
    output logic [VERTEX_BITS-1:0] o_vertex,
    output logic                   o_pf
);

    logic [VERTEX_BITS-1:0] r_vertex;
    logic                   r_pf;

    // Load a new entry, else take the neighbor's entry on a pop, else hold.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_vertex <= i_load_vertex;
            r_pf     <= i_load_pf;
        end else if (i_ctl.shift) begin
            r_vertex <= i_nb_vertex;
            r_pf     <= i_nb_pf;
        end
    end

    assign o_vertex = r_vertex;
    assign o_pf     = r_pf;

endmodule

>>> hdl/vrt_queue.sv
module vrt_queue #(
    parameter int DEPTH       = 16,
    parameter int VERTEX_BITS = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  vrt_pkg::t_q_ctl        i_ctl,
    input  logic [VERTEX_BITS-1:0] i_vertex,
    input  logic                   i_pf,
    output logic [VERTEX_BITS-1:0] o_head_vertex,
    output logic                   o_head_pf,
    output vrt_pkg::t_q_sts        o_sts
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [CW-1:0]          w_count_m1;
    logic [VERTEX_BITS-1:0] w_vertex [DEPTH];
    logic                   w_pf     [DEPTH];

    assign w_count_m1 = r_count - CW'(1);

    always_comb begin
        n_count = r_count;
        if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_ctl.push && i_ctl.pop) begin
            n_count = w_count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Cell 0 is the head; a pop shifts every cell one place toward it.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            vrt_pkg::t_cell_ctl     w_ctl;
            logic [VERTEX_BITS-1:0] w_nb_vertex;
            logic                   w_nb_pf;

            // A push with a pop lands one place lower; into an empty queue
            // it goes straight out and is not stored.
            always_comb begin
                w_ctl.shift = i_ctl.pop;
                if (i_ctl.pop) begin
                    w_ctl.load = i_ctl.push && (r_count != '0) && (w_count_m1 == CW'(gi));
                end else begin
                    w_ctl.load = i_ctl.push && (r_count == CW'(gi));
                end
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_nb_vertex = w_vertex[gi];
                assign w_nb_pf     = w_pf[gi];
            end else begin : g_mid
                assign w_nb_vertex = w_vertex[gi+1];
                assign w_nb_pf     = w_pf[gi+1];
            end

            vrt_cell #(
                .VERTEX_BITS (VERTEX_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_load_vertex (i_vertex),
                .i_load_pf     (i_pf),
                .i_nb_vertex   (w_nb_vertex),
                .i_nb_pf       (w_nb_pf),
                .o_vertex      (w_vertex[gi]),
                .o_pf          (w_pf[gi])
            );
        end
    endgenerate

    assign o_head_vertex    = w_vertex[0];
    assign o_head_pf        = w_pf[0];
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = (r_count == CW'(DEPTH));
    assign o_sts.empty_next = (n_count == '0);
    assign o_sts.full_next  = (n_count == CW'(DEPTH));

endmodule

>>> hdl/vertex_read_tracker.sv
// Vertex read tracker: source-side stage of a vertex-update pipeline.
// i_upd (sink) carries one transaction per cycle while ready is high: an
// optional vertex update, an optional vertex-memory response and the
// iteration-end marker. o_res (source) returns exactly one result
// transaction for each one accepted: the memory read to issue, the update
// to emit, the forwarded iteration end and the queue-full flag.
// A pull update, unless the queue is full, issues a read (at -2 for a
// power-law vertex, id == value) and parks its id and pull-first flag in
// a queue of QUEUE_DEPTH cells; a memory response pops the head cell, which
// may be the entry pushed in the same transaction. The queue is a row of
// cells that shifts toward the head on every pop, so the head is always
// read from the first cell. The result is registered and reaches o_res in
// the cycle after acceptance. Throughput: one transaction per cycle unless
// o_res stalls; the logic is bounded by the cell write-position compare.
// Reset (synchronous, active low) empties the queue, drops any pending
// result and clears the was-empty flag, so an iteration end in the first
// transaction after reset is not forwarded. Queue cell contents are not reset.
// When the receiver stalls, the result register holds and i_upd.ready drops
// until the result is taken; it rises again in the cycle the result leaves.
module vertex_read_tracker #(
    parameter int QUEUE_DEPTH = 16,
    parameter int VERTEX_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vrt_upd_if.sink   i_upd,
    vrt_res_if.source o_res
);

    localparam int AW = VERTEX_BITS + 1;
    localparam logic signed [AW-1:0] SENT = AW'(vrt_pkg::SENTINEL);

    vrt_pkg::t_q_ctl        w_ctl;
    vrt_pkg::t_q_sts        w_sts;
    logic [VERTEX_BITS-1:0] w_head_vertex;
    logic                   w_head_pf;
    logic                   w_acc;

    // Result register and its next value.
    logic                   r_out_vld;
    logic signed [AW-1:0]   r_rd_addr,  n_rd_addr;
    logic                   r_rd_vld,   n_rd_vld;
    logic                   r_is_push,  n_is_push;
    logic [VERTEX_BITS-1:0] r_vertex,   n_vertex;
    logic [VERTEX_BITS-1:0] r_value,    n_value;
    logic                   r_pf,       n_pf;
    logic                   r_upd_vld,  n_upd_vld;
    logic                   r_iend,     n_iend;
    logic                   r_full,     n_full;
    logic                   r_was_empty;

    // Accept whenever the result register is free or being drained.
    assign i_upd.ready = !r_out_vld || o_res.ready;
    assign w_acc       = i_upd.valid && i_upd.ready;

    // Push a pull update unless the queue is full; pop on any response that
    // has an entry to match (an existing one or the one pushed now).
    assign w_ctl.push = w_acc && i_upd.update_valid && !i_upd.update_is_push && !w_sts.full;
    assign w_ctl.pop  = w_acc && i_upd.memory_valid && (!w_sts.empty || w_ctl.push);

    vrt_queue #(
        .DEPTH       (QUEUE_DEPTH),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_vertex      (i_upd.update_vertex),
        .i_pf          (i_upd.update_pull_first),
        .o_head_vertex (w_head_vertex),
        .o_head_pf     (w_head_pf),
        .o_sts         (w_sts)
    );

    always_comb begin
        // Read request.
        n_rd_vld  = w_ctl.push;
        n_rd_addr = '0;
        if (w_ctl.push) begin
            if (i_upd.update_vertex == i_upd.update_value) begin
                n_rd_addr = SENT;
            end else begin
                n_rd_addr = {1'b0, i_upd.update_value};
            end
        end

        // Emitted update: a response wins and drops any push update.
        n_is_push = 1'b0;
        n_vertex  = '0;
        n_value   = '0;
        n_pf      = 1'b0;
        n_upd_vld = 1'b0;
        if (i_upd.memory_valid) begin
            n_upd_vld = 1'b1;
            if (i_upd.memory_data == SENT) begin
                n_value = i_upd.iteration_number;
            end else begin
                n_value = i_upd.memory_data[VERTEX_BITS-1:0];
            end
            if (w_ctl.pop) begin
                // Empty queue: the entry pushed now is the head.
                if (w_sts.empty) begin
                    n_vertex = i_upd.update_vertex;
                    n_pf     = i_upd.update_pull_first;
                end else begin
                    n_vertex = w_head_vertex;
                    n_pf     = w_head_pf;
                end
            end
        end else if (i_upd.update_valid && i_upd.update_is_push) begin
            n_is_push = 1'b1;
            n_vertex  = i_upd.update_vertex;
            n_value   = i_upd.update_value;
            n_upd_vld = 1'b1;
        end

        n_iend = i_upd.iteration_end_in && r_was_empty;
        n_full = w_sts.full_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_was_empty <= 1'b0;
        end else begin
            if (w_acc) begin
                r_out_vld   <= 1'b1;
                r_was_empty <= w_sts.empty_next;
            end else if (o_res.ready) begin
                r_out_vld   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd_addr <= n_rd_addr;
            r_rd_vld  <= n_rd_vld;
            r_is_push <= n_is_push;
            r_vertex  <= n_vertex;
            r_value   <= n_value;
            r_pf      <= n_pf;
            r_upd_vld <= n_upd_vld;
            r_iend    <= n_iend;
            r_full    <= n_full;
        end
    end

    assign o_res.valid             = r_out_vld;
    assign o_res.read_address      = r_rd_addr;
    assign o_res.read_valid        = r_rd_vld;
    assign o_res.out_is_push       = r_is_push;
    assign o_res.out_vertex        = r_vertex;
    assign o_res.out_value         = r_value;
    assign o_res.out_pull_first    = r_pf;
    assign o_res.out_valid         = r_upd_vld;
    assign o_res.iteration_end_out = r_iend;
    assign o_res.queue_full        = r_full;

    // A full queue never takes another entry.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.full |-> !w_ctl.push)
        else $error("push into full queue");

    // A pop from an empty queue must be matched by a push in the same cycle.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.pop && w_sts.empty) |-> w_ctl.push)
        else $error("pop from empty queue without a push");

    // Every accepted transaction shows a result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_out_vld)
        else $error("accepted transaction produced no result");

    // A read is reported only together with a pull push into the queue.
    a_read_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_rd_vld == $past(w_ctl.push)))
        else $error("read_valid does not match the queue push");

endmodule
